// File: rtl/core/ieet_pkg.sv
// shared types, codes and constants for the irregular ema estimate table
`timescale 1ns / 1ps

package ieet_pkg;

    localparam int ENTRIES_DEF = 64;

    // request codes
    localparam logic [1:0] REQ_UPDATE  = 2'd0;
    localparam logic [1:0] REQ_QUERY   = 2'd1;
    localparam logic [1:0] REQ_LOAD    = 2'd2;
    localparam logic [1:0] REQ_INVALID = 2'd3;

    // outcome codes
    localparam logic [1:0] OUT_IGNORED  = 2'd0;
    localparam logic [1:0] OUT_CANCELED = 2'd1;
    localparam logic [1:0] OUT_COUNTED  = 2'd2;
    localparam logic [1:0] OUT_SPARE    = 2'd3;

    // fixed point constants
    localparam logic [32:0] ONE32 = 33'h1_0000_0000;
    localparam logic [24:0] ONE24 = 25'h100_0000;
    // exp(-1) with 32 fractional bits, truncated series at f = 1
    localparam logic [31:0] E1 = 32'd1580030169;
    localparam logic [4:0]  SERIES_TERMS = 5'd16;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  entry;
        logic [31:0] sample_ms;
        logic [43:0] time_ms;
        logic [31:0] window_ms;
        logic [1:0]  outcome;
        logic [31:0] fallback_ms;
    } req_t;

    typedef struct packed {
        logic [31:0] estimate_ms;
        logic        applied;
    } rsp_t;

    typedef struct packed {
        logic [31:0] est;
        logic [31:0] last;
        logic [43:0] stamp;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [6:0]  nbits;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_DISPATCH,
        ST_CLASSIFY,
        ST_AQ_ISSUE,
        ST_AQ_WAIT,
        ST_SER_MUL,
        ST_SER_RCP,
        ST_SER_ACC,
        ST_POW,
        ST_POW_ACC,
        ST_V_ISSUE,
        ST_V_WAIT,
        ST_Q_ISSUE,
        ST_Q_WAIT,
        ST_MIX_MUL,
        ST_MIX_ACC,
        ST_MIX_END,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/ieet_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ieet_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  ieet_pkg::div_req_t req,
    output ieet_pkg::div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;
    logic        ge;
    logic [6:0]  shamt;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[63]};
        ge        = trial >= {1'b0, d_reg};
        shamt     = 7'd64 - req.nbits;
        if (req.start)
        begin
            // align dividend so its top bit leaves first
            q_next    = req.dividend << shamt;
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = req.nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
            q_next   = {q_reg[62:0], ge};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// File: rtl/core/ieet_store.sv
// entry memory: estimate, last sample and stamp, one read and one write port
`timescale 1ns / 1ps

module ieet_store
#(
    parameter int ENTRIES = ieet_pkg::ENTRIES_DEF,
    parameter int AW      = 6
)
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output ieet_pkg::entry_t    rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  ieet_pkg::entry_t    wr_data
);

    ieet_pkg::entry_t mem_reg [ENTRIES];
    ieet_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/irregular_ema_estimate_table.sv
// top level: irregular ema estimate table with sequencer and shared units
`timescale 1ns / 1ps

// A table of ENTRIES estimator entries (estimate, last sample, stamp) that
// folds irregularly spaced duration samples into an exponential moving
// average, answers blended queries toward a fallback, and loads entries.
// One word is taken at a time; in_ready is high only while the sequencer
// is idle, and the next word may be taken while a finished result still
// sits in the output register. The divisions by the window and by a come
// from one shared restoring divider at one bit per cycle, the series
// divisions by the term index use a small reciprocal table, and every
// product comes from one shared 33x32 multiplier. A load, an invalid
// request, an ignored or cancel-below-estimate update or a zero-window
// update goes to the result without these units; a query runs the mix,
// after one division when the age is nonzero and inside the window; a
// counted update runs age over window, the series terms, one e^-1 factor
// per unit of the integer part of age/window, the v division and the mix;
// an integer part of 32 or more skips the series. A result waits in the
// done state while out_ready holds the output register. Entries never
// loaded or updated read as undefined; there is no clearing pass after reset.

module irregular_ema_estimate_table
#(
    parameter int ENTRIES = ieet_pkg::ENTRIES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ieet_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ieet_pkg::rsp_t out_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = (AW > 6) ? AW : 6;

    // sequencer state and request word
    ieet_pkg::state_t state_reg, state_next;
    ieet_pkg::req_t   req_reg, req_next;

    // entry contents
    logic [31:0] est_reg, est_next;
    logic [31:0] last_reg, last_next;
    logic [43:0] stamp_reg, stamp_next;
    logic [44:0] diff_reg, diff_next;

    // ema datapath
    logic        newer_reg, newer_next;
    logic        query_reg, query_next;
    logic [43:0] age_reg, age_next;
    logic [31:0] older_reg, older_next;
    logic [31:0] newval_reg, newval_next;
    logic [31:0] aq_reg, aq_next;
    logic [15:0] x_reg, x_next;
    logic [4:0]  n_reg, n_next;
    logic [4:0]  k_reg, k_next;
    logic [32:0] term_reg, term_next;
    logic [33:0] sum_reg, sum_next;
    logic [24:0] u_reg, u_next;
    logic [24:0] v_reg, v_next;
    logic [1:0]  step_reg, step_next;
    logic [57:0] acc_reg, acc_next;
    logic [64:0] p_reg, p_next;

    // result and output register
    logic [31:0]    res_est_reg, res_est_next;
    logic           res_app_reg, res_app_next;
    logic           wr_flag_reg, wr_flag_next;
    logic           out_valid_reg, out_valid_next;
    ieet_pkg::rsp_t out_data_reg, out_data_next;

    // shared units
    ieet_pkg::div_req_t div_req;
    ieet_pkg::div_rsp_t div_rsp;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    // memory port
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     addr;
    logic [IW-1:0]     idx_w;
    ieet_pkg::entry_t  rd_data;
    ieet_pkg::entry_t  wr_data;

    // scratch
    logic        idx_ok;
    logic        newer_c;
    logic [43:0] age_c;
    logic [31:0] aq_c;
    logic [33:0] ut;
    logic [25:0] uraw;
    logic [32:0] onem;
    logic [49:0] vt;
    logic [41:0] vraw;
    logic [24:0] vc;
    logic [57:0] rnd;
    logic [35:0] rcp;
    logic [32:0] ser_q;
    logic        out_load;

    // floor(n / k) = (n * m) >> (32 + l) for 32-bit n, l = ceil(log2 k)
    // packed as {l, m}
    function automatic logic [35:0] recip_of(input logic [4:0] k);
        case (k)
            5'd1:    return {3'd0, 33'h1_0000_0001};
            5'd2:    return {3'd1, 33'h1_0000_0001};
            5'd3:    return {3'd2, 33'h1_5555_5556};
            5'd4:    return {3'd2, 33'h1_0000_0001};
            5'd5:    return {3'd3, 33'h1_9999_999A};
            5'd6:    return {3'd3, 33'h1_5555_5556};
            5'd7:    return {3'd3, 33'h1_2492_4925};
            5'd8:    return {3'd3, 33'h1_0000_0001};
            5'd9:    return {3'd4, 33'h1_C71C_71C8};
            5'd10:   return {3'd4, 33'h1_9999_999A};
            5'd11:   return {3'd4, 33'h1_745D_1746};
            5'd12:   return {3'd4, 33'h1_5555_5556};
            5'd13:   return {3'd4, 33'h1_3B13_B13C};
            5'd14:   return {3'd4, 33'h1_2492_4925};
            5'd15:   return {3'd4, 33'h1_1111_1112};
            5'd16:   return {3'd4, 33'h1_0000_0001};
            default: return {3'd0, 33'h1_0000_0001};
        endcase
    endfunction

    assign idx_w  = IW'(req_reg.entry);
    assign addr   = idx_w[AW-1:0];
    assign idx_ok = {26'd0, in_data.entry} < 32'(ENTRIES);
    assign mul_p  = 65'(mul_a) * 65'(mul_b);

    assign in_ready = (state_reg == ieet_pkg::ST_IDLE);
    assign out_load = (state_reg == ieet_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign rd_en    = (state_reg == ieet_pkg::ST_RD);
    assign wr_en    = out_load && wr_flag_reg;

    // full entry write: a newer sample (or a load) moves stamp and last sample
    assign wr_data.est   = res_est_reg;
    assign wr_data.last  = newer_reg ? req_reg.sample_ms : last_reg;
    assign wr_data.stamp = newer_reg ? req_reg.time_ms : stamp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        est_next       = est_reg;
        last_next      = last_reg;
        stamp_next     = stamp_reg;
        diff_next      = diff_reg;
        newer_next     = newer_reg;
        query_next     = query_reg;
        age_next       = age_reg;
        older_next     = older_reg;
        newval_next    = newval_reg;
        aq_next        = aq_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        res_est_next   = res_est_reg;
        res_app_next   = res_app_reg;
        wr_flag_next   = wr_flag_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        div_req.start    = 1'b0;
        div_req.nbits    = 7'd64;
        div_req.dividend = '0;
        div_req.divisor  = 32'd1;
        mul_a            = '0;
        mul_b            = '0;

        newer_c = !diff_reg[44];
        age_c   = newer_c ? diff_reg[43:0] : 44'(44'd0 - diff_reg[43:0]);
        aq_c    = '0;
        ut      = 34'({1'b0, sum_reg[32:0]}) + 34'd128;
        uraw    = ut[33:8];
        onem    = ieet_pkg::ONE32 - sum_reg[32:0];
        vt      = div_rsp.quotient[49:0] + 50'd128;
        vraw    = vt[49:8];
        vc      = '0;
        rnd     = acc_reg + 58'(ieet_pkg::ONE24 - 25'd1);
        rcp     = recip_of(k_reg);
        ser_q   = 33'(p_reg >> (7'd32 + {4'd0, rcp[35:33]}));

        // output register frees on take
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ieet_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = ieet_pkg::ST_RD;
                    // range check on the incoming index, kept with the word
                    wr_flag_next = idx_ok;
                end
            end

            ieet_pkg::ST_RD:
            begin
                state_next = ieet_pkg::ST_DISPATCH;
            end

            ieet_pkg::ST_DISPATCH:
            begin
                est_next   = rd_data.est;
                last_next  = rd_data.last;
                stamp_next = rd_data.stamp;
                diff_next  = {1'b0, req_reg.time_ms} - {1'b0, rd_data.stamp};
                if (!wr_flag_reg || req_reg.req_type == ieet_pkg::REQ_INVALID)
                begin
                    // out of range or undefined request
                    res_est_next = '0;
                    res_app_next = 1'b0;
                    wr_flag_next = 1'b0;
                    state_next   = ieet_pkg::ST_DONE;
                end
                else if (req_reg.req_type == ieet_pkg::REQ_LOAD)
                begin
                    res_est_next = req_reg.sample_ms;
                    res_app_next = 1'b1;
                    wr_flag_next = 1'b1;
                    newer_next   = 1'b1;
                    state_next   = ieet_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ieet_pkg::ST_CLASSIFY;
                end
            end

            ieet_pkg::ST_CLASSIFY:
            begin
                acc_next  = '0;
                step_next = '0;
                if (req_reg.req_type == ieet_pkg::REQ_QUERY)
                begin
                    // query reuses the mix: est*(1-f) + fallback*f + newer*0
                    query_next   = 1'b1;
                    older_next   = req_reg.fallback_ms;
                    newval_next  = '0;
                    v_next       = ieet_pkg::ONE24;
                    res_app_next = 1'b0;
                    wr_flag_next = 1'b0;
                    age_next     = age_c;
                    if (req_reg.window_ms == 32'd0 ||
                        (newer_c && age_c >= {12'd0, req_reg.window_ms}))
                    begin
                        u_next     = '0;
                        state_next = ieet_pkg::ST_MIX_MUL;
                    end
                    else if (!newer_c || age_c == 44'd0)
                    begin
                        u_next     = ieet_pkg::ONE24;
                        state_next = ieet_pkg::ST_MIX_MUL;
                    end
                    else
                    begin
                        state_next = ieet_pkg::ST_Q_ISSUE;
                    end
                end
                else if (req_reg.outcome == ieet_pkg::OUT_IGNORED ||
                         (req_reg.outcome == ieet_pkg::OUT_CANCELED &&
                          req_reg.sample_ms < est_reg))
                begin
                    res_est_next = est_reg;
                    res_app_next = 1'b0;
                    wr_flag_next = 1'b0;
                    state_next   = ieet_pkg::ST_DONE;
                end
                else
                begin
                    query_next   = 1'b0;
                    newer_next   = newer_c;
                    older_next   = newer_c ? last_reg : req_reg.sample_ms;
                    newval_next  = newer_c ? req_reg.sample_ms : last_reg;
                    age_next     = (age_c == 44'd0) ? 44'd1 : age_c;
                    res_app_next = 1'b1;
                    wr_flag_next = 1'b1;
                    if (req_reg.window_ms == 32'd0)
                    begin
                        // zero window keeps the estimate
                        res_est_next = est_reg;
                        state_next   = ieet_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ieet_pkg::ST_AQ_ISSUE;
                    end
                end
            end

            ieet_pkg::ST_AQ_ISSUE:
            begin
                div_req.start    = 1'b1;
                div_req.nbits    = 7'd60;
                div_req.dividend = {4'd0, age_reg, 16'd0};
                div_req.divisor  = req_reg.window_ms;
                state_next       = ieet_pkg::ST_AQ_WAIT;
            end

            ieet_pkg::ST_AQ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // a in q16.16, saturated, never zero
                    if (div_rsp.quotient[63:32] != 32'd0)
                    begin
                        aq_c = 32'hFFFF_FFFF;
                    end
                    else if (div_rsp.quotient[31:0] == 32'd0)
                    begin
                        aq_c = 32'd1;
                    end
                    else
                    begin
                        aq_c = div_rsp.quotient[31:0];
                    end
                    aq_next = aq_c;
                    if (aq_c[31:21] != 11'd0)
                    begin
                        // integer part of 32 or more: exp underflows to zero
                        sum_next   = '0;
                        state_next = ieet_pkg::ST_V_ISSUE;
                    end
                    else
                    begin
                        x_next     = aq_c[15:0];
                        n_next     = aq_c[20:16];
                        k_next     = 5'd1;
                        term_next  = ieet_pkg::ONE32;
                        sum_next   = 34'(ieet_pkg::ONE32);
                        state_next = ieet_pkg::ST_SER_MUL;
                    end
                end
            end

            ieet_pkg::ST_SER_MUL:
            begin
                mul_a      = term_reg;
                mul_b      = {16'd0, x_reg};
                p_next     = mul_p;
                state_next = ieet_pkg::ST_SER_RCP;
            end

            ieet_pkg::ST_SER_RCP:
            begin
                // divide by the term index through its reciprocal
                mul_a      = rcp[32:0];
                mul_b      = p_reg[47:16];
                p_next     = mul_p;
                state_next = ieet_pkg::ST_SER_ACC;
            end

            ieet_pkg::ST_SER_ACC:
            begin
                term_next = ser_q;
                // alternating series: odd terms subtract
                if (k_reg[0])
                begin
                    sum_next = sum_reg - {1'b0, ser_q};
                end
                else
                begin
                    sum_next = sum_reg + {1'b0, ser_q};
                end
                if (k_reg == ieet_pkg::SERIES_TERMS)
                begin
                    state_next = ieet_pkg::ST_POW;
                end
                else
                begin
                    k_next     = k_reg + 5'd1;
                    state_next = ieet_pkg::ST_SER_MUL;
                end
            end

            ieet_pkg::ST_POW:
            begin
                // one e^-1 factor per unit of the integer part
                if (n_reg == 5'd0)
                begin
                    state_next = ieet_pkg::ST_V_ISSUE;
                end
                else
                begin
                    mul_a      = sum_reg[32:0];
                    mul_b      = ieet_pkg::E1;
                    p_next     = mul_p;
                    state_next = ieet_pkg::ST_POW_ACC;
                end
            end

            ieet_pkg::ST_POW_ACC:
            begin
                sum_next   = {1'b0, p_reg[64:32]};
                n_next     = n_reg - 5'd1;
                state_next = ieet_pkg::ST_POW;
            end

            ieet_pkg::ST_V_ISSUE:
            begin
                u_next           = (uraw > 26'(ieet_pkg::ONE24)) ? ieet_pkg::ONE24
                                                                  : uraw[24:0];
                div_req.start    = 1'b1;
                div_req.nbits    = 7'd49;
                div_req.dividend = {15'd0, onem, 16'd0};
                div_req.divisor  = aq_reg;
                state_next       = ieet_pkg::ST_V_WAIT;
            end

            ieet_pkg::ST_V_WAIT:
            begin
                if (div_rsp.done)
                begin
                    vc = (vraw > 42'(ieet_pkg::ONE24)) ? ieet_pkg::ONE24 : vraw[24:0];
                    v_next     = (vc < u_reg) ? u_reg : vc;
                    state_next = ieet_pkg::ST_MIX_MUL;
                end
            end

            ieet_pkg::ST_Q_ISSUE:
            begin
                div_req.start    = 1'b1;
                div_req.nbits    = 7'd56;
                div_req.dividend = {age_reg[39:0], 24'd0};
                div_req.divisor  = req_reg.window_ms;
                state_next       = ieet_pkg::ST_Q_WAIT;
            end

            ieet_pkg::ST_Q_WAIT:
            begin
                if (div_rsp.done)
                begin
                    u_next     = ieet_pkg::ONE24 - div_rsp.quotient[24:0];
                    state_next = ieet_pkg::ST_MIX_MUL;
                end
            end

            ieet_pkg::ST_MIX_MUL:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        mul_a = {8'd0, u_reg};
                        mul_b = est_reg;
                    end
                    2'd1:
                    begin
                        mul_a = {8'd0, 25'(v_reg - u_reg)};
                        mul_b = older_reg;
                    end
                    default:
                    begin
                        mul_a = {8'd0, 25'(ieet_pkg::ONE24 - v_reg)};
                        mul_b = newval_reg;
                    end
                endcase
                p_next     = mul_p;
                state_next = ieet_pkg::ST_MIX_ACC;
            end

            ieet_pkg::ST_MIX_ACC:
            begin
                acc_next = acc_reg + p_reg[57:0];
                if (step_reg == 2'd2)
                begin
                    state_next = ieet_pkg::ST_MIX_END;
                end
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = ieet_pkg::ST_MIX_MUL;
                end
            end

            ieet_pkg::ST_MIX_END:
            begin
                // query rounds down, update rounds up
                res_est_next = query_reg ? acc_reg[55:24] : rnd[55:24];
                state_next   = ieet_pkg::ST_DONE;
            end

            ieet_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.estimate_ms = res_est_reg;
                    out_data_next.applied     = res_app_reg;
                    state_next                = ieet_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ieet_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ieet_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        est_reg      <= est_next;
        last_reg     <= last_next;
        stamp_reg    <= stamp_next;
        diff_reg     <= diff_next;
        newer_reg    <= newer_next;
        query_reg    <= query_next;
        age_reg      <= age_next;
        older_reg    <= older_next;
        newval_reg   <= newval_next;
        aq_reg       <= aq_next;
        x_reg        <= x_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        p_reg        <= p_next;
        res_est_reg  <= res_est_next;
        res_app_reg  <= res_app_next;
        wr_flag_reg  <= wr_flag_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ieet_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ieet_store
    #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    )
    u_store
    (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_data)
    );

    // entry is written only together with its result word
    a_wr_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ieet_pkg::ST_DONE) && out_load)
        else $error("entry write outside result load");

    // divider is never restarted mid-division
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a query never reports a change
    a_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && req_reg.req_type == ieet_pkg::REQ_QUERY) |-> !res_app_reg && !wr_en)
        else $error("query marked applied");

    // after a result is loaded the block takes the next word
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> in_ready)
        else $error("not ready after result");

endmodule
